// ===== hdl/first_fit_range_allocator_unit_macros.svh =====
// Assertion macros for the range allocator checker
`ifndef FIRST_FIT_RANGE_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FFA_ASSERT_NOW(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("ffa check failed");

// next-cycle implication
`define FFA_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("ffa check failed");

`endif

// ===== hdl/ffa_pkg.sv =====
package ffa_pkg;

    localparam int UNIT_BITS  = 21;
    localparam int MAX_RANGES = 32;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [UNIT_BITS-1:0] CAP_LIMIT = {1'b1, {(UNIT_BITS-1){1'b0}}};
    localparam logic [UNIT_BITS-1:0] CAP_RESET = UNIT_BITS'(65536);

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_PLAN  = 2'd2;
    localparam logic [1:0] OP_APPLY = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD    = 2'd1;
    localparam logic [1:0] ST_NOFIT  = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_SHDN = 5'b00100,
        S_SHUP = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic                 en;
        logic [IDX_W-1:0]     idx;
        logic [UNIT_BITS-1:0] off;
        logic [UNIT_BITS-1:0] len;
    } list_wr_t;

endpackage

// ===== hdl/ffa_list.sv =====
module ffa_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [ffa_pkg::IDX_W-1:0]     rd_idx,
    output logic [ffa_pkg::UNIT_BITS-1:0] rd_off,
    output logic [ffa_pkg::UNIT_BITS-1:0] rd_len,
    input  ffa_pkg::list_wr_t             wr
);

    logic [ffa_pkg::UNIT_BITS-1:0] off_reg [ffa_pkg::MAX_RANGES];
    logic [ffa_pkg::UNIT_BITS-1:0] len_reg [ffa_pkg::MAX_RANGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ffa_pkg::MAX_RANGES; i++)
            begin
                off_reg[i] <= '0;
                len_reg[i] <= (i == 0) ? ffa_pkg::CAP_RESET : '0;
            end
        end
        else if (wr.en)
        begin
            off_reg[wr.idx] <= wr.off;
            len_reg[wr.idx] <= wr.len;
        end
    end

    assign rd_off = off_reg[rd_idx];
    assign rd_len = len_reg[rd_idx];

endmodule

// ===== hdl/first_fit_range_allocator_unit.sv =====
// Allocate/free walk the list one entry per cycle, then shift entries one per
// cycle to close or open a slot. Apply leaves free only [start_req, cap).
// Defrag plan: one result per relocation (or one, if none), last on the final.
// Throughput: one item at a time; busy stays high until the final result.
// Reset: capacity 65536, one free range [0,65536); receiver cannot stall.
module first_fit_range_allocator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    op,
    input  logic [ffa_pkg::UNIT_BITS-1:0] start_req,
    input  logic [ffa_pkg::UNIT_BITS-1:0] length,
    input  logic                          cfg_wen,
    input  logic [ffa_pkg::UNIT_BITS-1:0] cfg_wdata,
    output logic                          strobe,
    output logic [1:0]                    status,
    output logic [ffa_pkg::UNIT_BITS-1:0] place,
    output logic [ffa_pkg::UNIT_BITS-1:0] moved_from,
    output logic [ffa_pkg::UNIT_BITS-1:0] moved_to,
    output logic [ffa_pkg::UNIT_BITS-1:0] moved_length,
    output logic [ffa_pkg::UNIT_BITS-1:0] compact_end,
    output logic [ffa_pkg::UNIT_BITS-1:0] free_total,
    output logic [ffa_pkg::CNT_W-1:0]     free_range_count,
    output logic                          last
);

    localparam int UB = ffa_pkg::UNIT_BITS;
    localparam int CW = ffa_pkg::CNT_W;
    localparam int IW = ffa_pkg::IDX_W;

    ffa_pkg::state_t state_reg, state_next;
    logic [UB-1:0] cap_reg, cap_next, free_reg, free_next;
    logic [CW-1:0] total_reg, total_next, idx_reg, idx_next, ins_reg, ins_next;
    logic [1:0]    op_reg, op_next;
    logic [UB-1:0] sreq_reg, sreq_next, len_reg, len_next;
    logic          seen_reg, seen_next;
    logic [UB-1:0] poff_reg, poff_next, plen_reg, plen_next;
    logic [UB:0]   pend_reg, pend_end_next;
    logic [UB-1:0] noff_reg, noff_next, nlen_reg, nlen_next;
    logic [UB-1:0] shift_reg, shift_next, seg_reg, seg_next;
    logic          pv_reg, pv_next;
    logic [UB-1:0] pf_reg, pf_next, pt_reg, pt_next, pl_reg, pl_next;
    logic [1:0]    rst_reg, rst_next;
    logic [UB-1:0] rplace_reg, rplace_next;

    logic          strobe_reg, strobe_next, last_reg, last_next;
    logic [1:0]    status_reg, status_next;
    logic [UB-1:0] place_reg, place_next, mf_reg, mf_next, mt_reg, mt_next;
    logic [UB-1:0] ml_reg, ml_next, ce_reg, ce_next, ft_reg, ft_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    logic [IW-1:0]     rd_idx;
    logic [UB-1:0]     rd_off, rd_len;
    ffa_pkg::list_wr_t wr;

    logic [CW-1:0] idx_p1, idx_m1;
    logic [UB:0]   req_end, ent_end;
    logic          at_end, cand, jp, jn;
    logic [UB-1:0] c_lim, sat;

    ffa_list u_list (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_idx (rd_idx),
        .rd_off (rd_off),
        .rd_len (rd_len),
        .wr     (wr)
    );

    assign idx_p1  = idx_reg + CW'(1);
    assign idx_m1  = idx_reg - CW'(1);
    assign rd_idx  = (state_reg == ffa_pkg::S_SHDN) ? idx_p1[IW-1:0] :
                     (state_reg == ffa_pkg::S_SHUP) ? idx_m1[IW-1:0] : idx_reg[IW-1:0];
    assign req_end = {1'b0, sreq_reg} + {1'b0, len_reg};
    assign ent_end = {1'b0, rd_off} + {1'b0, rd_len};
    assign at_end  = idx_reg >= total_reg;
    assign c_lim   = at_end ? cap_reg : rd_off;
    assign cand    = (c_lim > seg_reg) && (shift_reg != '0);
    assign jp      = (ins_reg != '0) && (pend_reg == {1'b0, sreq_reg});
    assign jn      = seen_reg && ({1'b0, noff_reg} == req_end);
    assign sat     = (cfg_wdata > ffa_pkg::CAP_LIMIT) ? ffa_pkg::CAP_LIMIT : cfg_wdata;

    always_comb
    begin
        state_next  = state_reg;
        cap_next    = cap_reg;
        free_next   = free_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        ins_next    = ins_reg;
        op_next     = op_reg;
        sreq_next   = sreq_reg;
        len_next    = len_reg;
        seen_next   = seen_reg;
        poff_next   = poff_reg;
        plen_next   = plen_reg;
        pend_end_next = pend_reg;
        noff_next   = noff_reg;
        nlen_next   = nlen_reg;
        shift_next  = shift_reg;
        seg_next    = seg_reg;
        pv_next     = pv_reg;
        pf_next     = pf_reg;
        pt_next     = pt_reg;
        pl_next     = pl_reg;
        rst_next    = rst_reg;
        rplace_next = rplace_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        status_next = status_reg;
        place_next  = place_reg;
        mf_next     = mf_reg;
        mt_next     = mt_reg;
        ml_next     = ml_reg;
        ce_next     = ce_reg;
        ft_next     = ft_reg;
        cnt_next    = cnt_reg;
        wr          = '0;

        case (state_reg)
            ffa_pkg::S_IDLE:
            begin
                if (cfg_wen)
                begin
                    cap_next   = sat;
                    free_next  = sat;
                    total_next = CW'(sat != '0);
                    wr         = '{en: 1'b1, idx: '0, off: '0, len: sat};
                end
                if (start)
                begin
                    op_next     = op;
                    sreq_next   = start_req;
                    len_next    = length;
                    idx_next    = '0;
                    ins_next    = '0;
                    seen_next   = 1'b0;
                    shift_next  = '0;
                    seg_next    = '0;
                    pv_next     = 1'b0;
                    rplace_next = '0;
                    rst_next    = ffa_pkg::ST_OK;
                    state_next  = ffa_pkg::S_WALK;
                    case (op)
                        ffa_pkg::OP_ALLOC:
                            if (length == '0 || length > cap_reg)
                            begin
                                rst_next   = ffa_pkg::ST_BAD;
                                state_next = ffa_pkg::S_OUT;
                            end
                        ffa_pkg::OP_FREE:
                            if (length == '0 ||
                                ({1'b0, start_req} + {1'b0, length}) > {1'b0, cap_reg})
                            begin
                                rst_next   = ffa_pkg::ST_BAD;
                                state_next = ffa_pkg::S_OUT;
                            end
                        ffa_pkg::OP_APPLY:
                            if (start_req > cap_reg)
                            begin
                                rst_next   = ffa_pkg::ST_BAD;
                                state_next = ffa_pkg::S_OUT;
                            end
                        default: ;
                    endcase
                end
            end

            ffa_pkg::S_WALK:
            begin
                case (op_reg)
                    ffa_pkg::OP_ALLOC:
                    begin
                        if (at_end)
                        begin
                            rst_next   = ffa_pkg::ST_NOFIT;
                            state_next = ffa_pkg::S_OUT;
                        end
                        else if (rd_len >= len_reg)
                        begin
                            rplace_next = rd_off;
                            free_next   = free_reg - len_reg;
                            if (rd_len != len_reg)
                            begin
                                wr = '{en: 1'b1, idx: idx_reg[IW-1:0],
                                       off: rd_off + len_reg, len: rd_len - len_reg};
                                state_next = ffa_pkg::S_OUT;
                            end
                            else
                                state_next = ffa_pkg::S_SHDN;
                        end
                        else
                            idx_next = idx_p1;
                    end

                    ffa_pkg::OP_FREE:
                    begin
                        if (at_end)
                        begin
                            state_next = ffa_pkg::S_OUT;
                            if (jp && jn)
                            begin
                                wr = '{en: 1'b1, idx: idx_m1[IW-1:0] - IW'(idx_reg - ins_reg),
                                       off: poff_reg, len: plen_reg + len_reg + nlen_reg};
                                free_next  = free_reg + len_reg;
                                idx_next   = ins_reg;
                                state_next = ffa_pkg::S_SHDN;
                            end
                            else if (jp)
                            begin
                                wr = '{en: 1'b1, idx: IW'(ins_reg - CW'(1)),
                                       off: poff_reg, len: plen_reg + len_reg};
                                free_next = free_reg + len_reg;
                            end
                            else if (jn)
                            begin
                                wr = '{en: 1'b1, idx: ins_reg[IW-1:0],
                                       off: sreq_reg, len: nlen_reg + len_reg};
                                free_next = free_reg + len_reg;
                            end
                            else if (total_reg >= CW'(ffa_pkg::MAX_RANGES))
                                rst_next = ffa_pkg::ST_FULL;
                            else
                            begin
                                free_next  = free_reg + len_reg;
                                idx_next   = total_reg;
                                state_next = ffa_pkg::S_SHUP;
                            end
                        end
                        else if ({1'b0, sreq_reg} < ent_end && {1'b0, rd_off} < req_end)
                        begin
                            rst_next   = ffa_pkg::ST_BAD;
                            state_next = ffa_pkg::S_OUT;
                        end
                        else
                        begin
                            idx_next = idx_p1;
                            if (rd_off < sreq_reg)
                            begin
                                pend_end_next = ent_end;
                                poff_next     = rd_off;
                                plen_next     = rd_len;
                                ins_next      = idx_p1;
                            end
                            else if (!seen_reg)
                            begin
                                seen_next = 1'b1;
                                noff_next = rd_off;
                                nlen_next = rd_len;
                            end
                        end
                    end

                    ffa_pkg::OP_PLAN:
                    begin
                        if (cand)
                        begin
                            if (pv_reg)
                            begin
                                strobe_next = 1'b1;
                                status_next = ffa_pkg::ST_OK;
                                place_next  = '0;
                                mf_next     = pf_reg;
                                mt_next     = pt_reg;
                                ml_next     = pl_reg;
                                ce_next     = cap_reg - free_reg;
                                ft_next     = free_reg;
                                cnt_next    = total_reg;
                            end
                            pv_next = 1'b1;
                            pf_next = seg_reg;
                            pt_next = seg_reg - shift_reg;
                            pl_next = c_lim - seg_reg;
                        end
                        if (at_end)
                            state_next = ffa_pkg::S_OUT;
                        else
                        begin
                            shift_next = shift_reg + rd_len;
                            seg_next   = rd_off + rd_len;
                            idx_next   = idx_p1;
                        end
                    end

                    default:
                    begin
                        free_next  = cap_reg - sreq_reg;
                        total_next = CW'(sreq_reg < cap_reg);
                        wr = '{en: sreq_reg < cap_reg, idx: '0,
                               off: sreq_reg, len: cap_reg - sreq_reg};
                        state_next = ffa_pkg::S_OUT;
                    end
                endcase
            end

            ffa_pkg::S_SHDN:
            begin
                if (idx_p1 >= total_reg)
                begin
                    total_next = total_reg - CW'(1);
                    state_next = ffa_pkg::S_OUT;
                end
                else
                begin
                    wr = '{en: 1'b1, idx: idx_reg[IW-1:0], off: rd_off, len: rd_len};
                    idx_next = idx_p1;
                end
            end

            ffa_pkg::S_SHUP:
            begin
                if (idx_reg == ins_reg)
                begin
                    wr = '{en: 1'b1, idx: idx_reg[IW-1:0], off: sreq_reg, len: len_reg};
                    total_next = total_reg + CW'(1);
                    state_next = ffa_pkg::S_OUT;
                end
                else
                begin
                    wr = '{en: 1'b1, idx: idx_reg[IW-1:0], off: rd_off, len: rd_len};
                    idx_next = idx_m1;
                end
            end

            ffa_pkg::S_OUT:
            begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
                status_next = rst_reg;
                place_next  = rplace_reg;
                mf_next     = pv_reg ? pf_reg : '0;
                mt_next     = pv_reg ? pt_reg : '0;
                ml_next     = pv_reg ? pl_reg : '0;
                ce_next     = cap_reg - free_reg;
                ft_next     = free_reg;
                cnt_next    = total_reg;
                state_next  = ffa_pkg::S_IDLE;
            end

            default: state_next = ffa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ffa_pkg::S_IDLE;
            cap_reg    <= ffa_pkg::CAP_RESET;
            free_reg   <= ffa_pkg::CAP_RESET;
            total_reg  <= CW'(1);
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cap_reg    <= cap_next;
            free_reg   <= free_next;
            total_reg  <= total_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        ins_reg    <= ins_next;
        op_reg     <= op_next;
        sreq_reg   <= sreq_next;
        len_reg    <= len_next;
        seen_reg   <= seen_next;
        poff_reg   <= poff_next;
        plen_reg   <= plen_next;
        pend_reg   <= pend_end_next;
        noff_reg   <= noff_next;
        nlen_reg   <= nlen_next;
        shift_reg  <= shift_next;
        seg_reg    <= seg_next;
        pv_reg     <= pv_next;
        pf_reg     <= pf_next;
        pt_reg     <= pt_next;
        pl_reg     <= pl_next;
        rst_reg    <= rst_next;
        rplace_reg <= rplace_next;
        status_reg <= status_next;
        place_reg  <= place_next;
        mf_reg     <= mf_next;
        mt_reg     <= mt_next;
        ml_reg     <= ml_next;
        ce_reg     <= ce_next;
        ft_reg     <= ft_next;
        cnt_reg    <= cnt_next;
    end

    assign busy             = state_reg != ffa_pkg::S_IDLE;
    assign strobe           = strobe_reg;
    assign last             = last_reg;
    assign status           = status_reg;
    assign place            = place_reg;
    assign moved_from       = mf_reg;
    assign moved_to         = mt_reg;
    assign moved_length     = ml_reg;
    assign compact_end      = ce_reg;
    assign free_total       = ft_reg;
    assign free_range_count = cnt_reg;

endmodule

// ===== hdl/ffa_chk.sv =====
`include "first_fit_range_allocator_unit_macros.svh"

module ffa_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic        last,
    input logic [1:0]  status,
    input logic [20:0] place,
    input logic [20:0] moved_length,
    input logic [20:0] compact_end,
    input logic [20:0] free_total,
    input logic [5:0]  free_range_count
);

    `FFA_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `FFA_ASSERT_NOW(a_last_strobe, last, strobe)
    `FFA_ASSERT_NOW(a_err_clean, strobe && status != ffa_pkg::ST_OK,
                    place == '0 && moved_length == '0)
    `FFA_ASSERT_NOW(a_count_max, strobe, free_range_count <= 6'd32)
    `FFA_ASSERT_NOW(a_sum_cap, strobe,
                    ({1'b0, compact_end} + {1'b0, free_total}) <= 22'd1048576)

endmodule

bind first_fit_range_allocator_unit ffa_chk u_ffa_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .strobe           (strobe),
    .last             (last),
    .status           (status),
    .place            (place),
    .moved_length     (moved_length),
    .compact_end      (compact_end),
    .free_total       (free_total),
    .free_range_count (free_range_count)
);

// ===== verif/tb_first_fit_range_allocator_unit.sv =====
module tb_first_fit_range_allocator_unit;

    localparam int CYCLE_LIMIT = 900000;
    localparam logic [20:0] ALL_ONES = 21'h1fffff;
    localparam logic [1:0] NO_TYPED = 2'bxx;

    typedef struct packed {
        logic [1:0]  st;
        logic [20:0] place;
        logic [20:0] mfrom;
        logic [20:0] mto;
        logic [20:0] mlen;
        logic [20:0] cend;
        logic [20:0] ftot;
        logic [5:0]  cnt;
        logic        lst;
    } alloc_result_t;

    typedef struct {
        logic [1:0]  op;
        logic [20:0] sreq;
        logic [20:0] len;
        bit          typed;
        logic [1:0]  st;
        logic [20:0] place;
    } cmd_row_t;

    typedef struct {
        longint unsigned off;
        longint unsigned len;
    } seg_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [20:0] start_req;
    logic [20:0] length;
    logic        cfg_wen;
    logic [20:0] cfg_wdata;
    logic        strobe;
    logic [1:0]  status;
    logic [20:0] place;
    logic [20:0] moved_from;
    logic [20:0] moved_to;
    logic [20:0] moved_length;
    logic [20:0] compact_end;
    logic [20:0] free_total;
    logic [5:0]  free_range_count;
    logic        last;

    longint unsigned pool_units;
    longint unsigned free_off [ffa_pkg::MAX_RANGES];
    longint unsigned free_len [ffa_pkg::MAX_RANGES];
    int              free_cnt;

    alloc_result_t expected_q [$];
    seg_t          held_q [$];
    int            errors;
    int            cycles;
    bit            no_idle;

    first_fit_range_allocator_unit u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .op(op), .start_req(start_req), .length(length),
        .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
        .strobe(strobe), .status(status), .place(place),
        .moved_from(moved_from), .moved_to(moved_to), .moved_length(moved_length),
        .compact_end(compact_end), .free_total(free_total),
        .free_range_count(free_range_count), .last(last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- free list model ----------------
    task automatic list_reset();
        for (int i = 0; i < ffa_pkg::MAX_RANGES; i++)
        begin
            free_off[i] = 0;
            free_len[i] = 0;
        end
        free_len[0] = pool_units;
        free_cnt = (pool_units != 0) ? 1 : 0;
        held_q.delete();
    endtask

    task automatic set_capacity(logic [20:0] v);
        pool_units = (v > ffa_pkg::CAP_LIMIT) ? ffa_pkg::CAP_LIMIT : v;
        list_reset();
    endtask

    function automatic void drop_range(int idx);
        for (int i = idx; i + 1 < free_cnt; i++)
        begin
            free_off[i] = free_off[i + 1];
            free_len[i] = free_len[i + 1];
        end
        free_cnt--;
    endfunction

    task automatic push_result(logic [1:0] st, longint unsigned plc, longint unsigned f,
                               longint unsigned t, longint unsigned l, bit lst);
        longint unsigned ft;
        alloc_result_t r;
        ft = 0;
        for (int i = 0; i < free_cnt; i++)
            ft += free_len[i];
        r.st = st;
        r.place = plc[20:0];
        r.mfrom = f[20:0];
        r.mto = t[20:0];
        r.mlen = l[20:0];
        r.cend = 21'(pool_units - ft);
        r.ftot = ft[20:0];
        r.cnt = 6'(free_cnt);
        r.lst = lst;
        expected_q.insert(expected_q.size(), r);
    endtask

    function automatic logic [1:0] alloc_units(longint unsigned len, output longint unsigned plc);
        plc = 0;
        if (len == 0 || len > pool_units)
            return ffa_pkg::ST_BAD;
        for (int i = 0; i < free_cnt; i++)
        begin
            if (free_len[i] >= len)
            begin
                plc = free_off[i];
                free_off[i] += len;
                free_len[i] -= len;
                if (free_len[i] == 0)
                    drop_range(i);
                return ffa_pkg::ST_OK;
            end
        end
        return ffa_pkg::ST_NOFIT;
    endfunction

    function automatic logic [1:0] release_units(longint unsigned s, longint unsigned len);
        longint unsigned e;
        int idx;
        bit jp;
        bit jn;
        e = s + len;
        idx = 0;
        if (len == 0 || e > pool_units)
            return ffa_pkg::ST_BAD;
        for (int i = 0; i < free_cnt; i++)
            if (s < free_off[i] + free_len[i] && free_off[i] < e)
                return ffa_pkg::ST_BAD;
        while (idx < free_cnt && free_off[idx] < s)
            idx++;
        jp = idx > 0 && free_off[idx - 1] + free_len[idx - 1] == s;
        jn = idx < free_cnt && free_off[idx] == e;
        if (jp && jn)
        begin
            free_len[idx - 1] += len + free_len[idx];
            drop_range(idx);
        end
        else if (jp)
            free_len[idx - 1] += len;
        else if (jn)
        begin
            free_off[idx] = s;
            free_len[idx] += len;
        end
        else
        begin
            if (free_cnt >= ffa_pkg::MAX_RANGES)
                return ffa_pkg::ST_FULL;
            for (int i = free_cnt; i > idx; i--)
            begin
                free_off[i] = free_off[i - 1];
                free_len[i] = free_len[i - 1];
            end
            free_off[idx] = s;
            free_len[idx] = len;
            free_cnt++;
        end
        return ffa_pkg::ST_OK;
    endfunction

    task automatic plan_moves();
        longint unsigned mf [$];
        longint unsigned mt [$];
        longint unsigned ml [$];
        longint unsigned shift;
        longint unsigned seg;
        shift = 0;
        seg = 0;
        for (int i = 0; i < free_cnt; i++)
        begin
            if (free_off[i] > seg && shift > 0)
            begin
                mf.insert(mf.size(), seg);
                mt.insert(mt.size(), seg - shift);
                ml.insert(ml.size(), free_off[i] - seg);
            end
            shift += free_len[i];
            seg = free_off[i] + free_len[i];
        end
        if (pool_units > seg && shift > 0)
        begin
            mf.insert(mf.size(), seg);
            mt.insert(mt.size(), seg - shift);
            ml.insert(ml.size(), pool_units - seg);
        end
        if (mf.size() == 0)
            push_result(ffa_pkg::ST_OK, 0, 0, 0, 0, 1'b1);
        for (int k = 0; k < mf.size(); k++)
            push_result(ffa_pkg::ST_OK, 0, mf[k], mt[k], ml[k], k == mf.size() - 1);
    endtask

    task automatic predict_item(logic [1:0] o, logic [20:0] s, logic [20:0] l);
        longint unsigned plc;
        logic [1:0] st;
        plc = 0;
        if (o == ffa_pkg::OP_PLAN)
        begin
            plan_moves();
            return;
        end
        if (o == ffa_pkg::OP_ALLOC)
        begin
            st = alloc_units(l, plc);
            if (st == ffa_pkg::ST_OK)
                held_q.insert(held_q.size(), seg_t'{plc, l});
        end
        else if (o == ffa_pkg::OP_FREE)
            st = release_units(s, l);
        else if (s > pool_units)
            st = ffa_pkg::ST_BAD;
        else
        begin
            for (int i = 0; i < ffa_pkg::MAX_RANGES; i++)
            begin
                free_off[i] = 0;
                free_len[i] = 0;
            end
            free_cnt = 0;
            held_q.delete();
            if (s < pool_units)
            begin
                free_off[0] = s;
                free_len[0] = pool_units - s;
                free_cnt = 1;
            end
            st = ffa_pkg::ST_OK;
        end
        push_result(st, plc, 0, 0, 0, 1'b1);
    endtask

    // ---------------- driving ----------------
    task automatic send_cmd(cmd_row_t c);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(99) < 24)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        op = c.op;
        start_req = c.sreq;
        length = c.len;
        do
            @(posedge clk);
        while (busy);
        predict_item(c.op, c.sreq, c.len);
        if (c.typed)
        begin
            expected_q[$].st = c.st;
            expected_q[$].place = c.place;
        end
    endtask

    task automatic send(logic [1:0] o, logic [20:0] s, logic [20:0] l);
        send_cmd('{o, s, l, 1'b0, NO_TYPED, 21'd0});
    endtask

    task automatic wait_drain();
        @(negedge clk);
        start = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_capacity(logic [20:0] v);
        wait_drain();
        cfg_wen = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_wen = 1'b0;
        set_capacity(v);
    endtask

    function automatic logic [20:0] pick_len();
        longint unsigned top;
        top = pool_units / 8;
        if (top < 1)
            top = 1;
        case ($urandom_range(19))
            0: return 21'd0;
            1: return 21'(pool_units + $urandom_range(1, 4));
            2: return 21'($urandom);
            3: return 21'(pool_units);
            default: return 21'($urandom_range(1, int'(top > 64 ? 64 + top % 997 : top)));
        endcase
    endfunction

    task automatic random_phase(int n);
        seg_t sg;
        int k;
        logic [20:0] s;
        logic [20:0] l;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 40)
                send(ffa_pkg::OP_ALLOC, 21'($urandom), pick_len());
            else if (k < 70 && held_q.size() != 0)
            begin
                k = $urandom_range(held_q.size() - 1);
                sg = held_q[k];
                held_q.delete(k);
                if (sg.len > 1 && $urandom_range(3) == 0)
                begin
                    l = 21'($urandom_range(1, int'(sg.len - 1)));
                    s = 21'(sg.off + (sg.len - l));
                    held_q.insert(held_q.size(), seg_t'{sg.off, sg.len - l});
                end
                else
                begin
                    s = sg.off;
                    l = sg.len;
                end
                send(ffa_pkg::OP_FREE, s, l);
            end
            else if (k < 80)
            begin
                s = 21'($urandom_range(0, int'(pool_units + 2)));
                send(ffa_pkg::OP_FREE, $urandom_range(1) ? s : 21'($urandom), pick_len());
            end
            else if (k < 96)
                send(ffa_pkg::OP_PLAN, 21'($urandom), 21'($urandom));
            else
                send(ffa_pkg::OP_APPLY, 21'($urandom_range(0, int'(pool_units + 1))),
                     21'($urandom));
        end
    endtask

    // ---------------- checking ----------------
    always @(posedge clk)
    begin
        alloc_result_t got;
        alloc_result_t want;
        if (rst_n && strobe)
        begin
            got = '{status, place, moved_from, moved_to, moved_length,
                    compact_end, free_total, free_range_count, last};
            if (expected_q.size() == 0)
            begin
                $display("%0t unexpected result %p", $time, got);
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    $display("%0t mismatch expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    cmd_row_t directed [] = '{
        '{ffa_pkg::OP_ALLOC, 21'd0,     21'd0,     1'b1, ffa_pkg::ST_BAD,   21'd0},
        '{ffa_pkg::OP_ALLOC, 21'd0,     21'd65537, 1'b1, ffa_pkg::ST_BAD,   21'd0},
        '{ffa_pkg::OP_ALLOC, 21'd0,     ALL_ONES,  1'b1, ffa_pkg::ST_BAD,   21'd0},
        '{ffa_pkg::OP_ALLOC, ALL_ONES,  21'd100,   1'b1, ffa_pkg::ST_OK,    21'd0},
        '{ffa_pkg::OP_ALLOC, 21'd0,     21'd200,   1'b1, ffa_pkg::ST_OK,    21'd100},
        '{ffa_pkg::OP_FREE,  21'd0,     21'd100,   1'b1, ffa_pkg::ST_OK,    21'd0},
        '{ffa_pkg::OP_FREE,  21'd50,    21'd10,    1'b1, ffa_pkg::ST_BAD,   21'd0},
        '{ffa_pkg::OP_FREE,  21'd65500, 21'd100,   1'b1, ffa_pkg::ST_BAD,   21'd0},
        '{ffa_pkg::OP_FREE,  ALL_ONES,  ALL_ONES,  1'b1, ffa_pkg::ST_BAD,   21'd0},
        '{ffa_pkg::OP_FREE,  21'd120,   21'd0,     1'b1, ffa_pkg::ST_BAD,   21'd0},
        '{ffa_pkg::OP_PLAN,  21'd0,     21'd0,     1'b0, NO_TYPED,          21'd0},
        '{ffa_pkg::OP_FREE,  21'd100,   21'd200,   1'b1, ffa_pkg::ST_OK,    21'd0},
        '{ffa_pkg::OP_PLAN,  ALL_ONES,  ALL_ONES,  1'b0, NO_TYPED,          21'd0},
        '{ffa_pkg::OP_APPLY, 21'd65537, 21'd0,     1'b1, ffa_pkg::ST_BAD,   21'd0},
        '{ffa_pkg::OP_APPLY, 21'd65536, 21'd0,     1'b1, ffa_pkg::ST_OK,    21'd0},
        '{ffa_pkg::OP_ALLOC, 21'd0,     21'd1,     1'b1, ffa_pkg::ST_NOFIT, 21'd0},
        '{ffa_pkg::OP_PLAN,  21'd0,     21'd0,     1'b0, NO_TYPED,          21'd0},
        '{ffa_pkg::OP_FREE,  21'd10,    21'd1,     1'b1, ffa_pkg::ST_OK,    21'd0},
        '{ffa_pkg::OP_PLAN,  21'd0,     21'd0,     1'b0, NO_TYPED,          21'd0},
        '{ffa_pkg::OP_APPLY, 21'd0,     21'd0,     1'b1, ffa_pkg::ST_OK,    21'd0},
        '{ffa_pkg::OP_ALLOC, 21'd0,     21'd65536, 1'b1, ffa_pkg::ST_OK,    21'd0},
        '{ffa_pkg::OP_FREE,  21'd65535, 21'd1,     1'b1, ffa_pkg::ST_OK,    21'd0},
        '{ffa_pkg::OP_APPLY, ALL_ONES,  ALL_ONES,  1'b1, ffa_pkg::ST_BAD,   21'd0}
    };

    initial
    begin
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        op = ffa_pkg::OP_ALLOC;
        start_req = '0;
        length = '0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        set_capacity(ffa_pkg::CAP_RESET);
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_cmd(directed[i]);

        // fill the list to its limit, then one isolated free
        write_capacity(21'd66);
        send(ffa_pkg::OP_ALLOC, 21'd0, 21'd66);
        for (int u = 0; u < 64; u += 2)
            send(ffa_pkg::OP_FREE, 21'(u), 21'd1);
        send_cmd('{ffa_pkg::OP_FREE, 21'd64, 21'd1, 1'b1, ffa_pkg::ST_FULL, 21'd0});
        send(ffa_pkg::OP_PLAN, 21'd0, 21'd0);
        random_phase(20);

        write_capacity(21'd0);
        send_cmd('{ffa_pkg::OP_ALLOC, 21'd0, 21'd1, 1'b1, ffa_pkg::ST_BAD, 21'd0});
        random_phase(8);

        write_capacity(ALL_ONES);
        send_cmd('{ffa_pkg::OP_ALLOC, 21'd0, ffa_pkg::CAP_LIMIT, 1'b1, ffa_pkg::ST_OK, 21'd0});
        send_cmd('{ffa_pkg::OP_FREE, 21'd0, ffa_pkg::CAP_LIMIT, 1'b1, ffa_pkg::ST_OK, 21'd0});
        random_phase(50);

        write_capacity(21'd1);
        random_phase(20);

        write_capacity(21'd300);
        no_idle = 1'b1;
        random_phase(100);
        no_idle = 1'b0;

        write_capacity(21'($urandom_range(1, 1 << 20)));
        random_phase(60);

        write_capacity(ffa_pkg::CAP_LIMIT);
        random_phase(60);

        write_capacity(21'd40);
        random_phase(60);

        wait_drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
